@@ src/dqhe_pkg.sv @@
`default_nettype none

package dqhe_pkg;

    // One input word: a payload byte or a host character.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_host;
        logic [6:0] payload_total;
        logic       name_end;
    } item_t;

    // One output word of the encoded name.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_last;
        logic       overflow;
    } result_t;

    // Operations that the front end hands to the back end.
    typedef enum logic [1:0] {
        OP_STORE,
        OP_STORE_FLUSH,
        OP_FLUSH,
        OP_CLOSE
    } op_t;

    // One command word in the queue between front and back.
    typedef struct packed {
        op_t        op;
        logic [7:0] chr;
        logic [5:0] addr;
        logic [5:0] len;
        logic       ovf;
        logic       first;
    } cmd_t;

    // Front end step within one input word.
    typedef enum logic [1:0] {
        FS_FIRST,
        FS_SECOND,
        FS_CLOSE
    } fr_step_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LEN,
        BK_CHAR,
        BK_CLOSE
    } bk_state_t;

    localparam int         QUEUE_DEPTH = 4;
    localparam logic [6:0] MAX_OUT     = 7'd64;
    localparam logic [5:0] LIMIT_RESET = 6'd63;
    localparam logic [5:0] LIMIT_MIN   = 6'd2;
    localparam logic [7:0] DOT_CHAR    = 8'h2E;
    localparam logic [7:0] END_BYTE    = 8'h00;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // Upper-case hex character of one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return HEX_DIGITS[nib];
    endfunction

endpackage

`default_nettype wire

@@ src/dns_qname_hex_label_encoder.sv @@
`default_nettype none

// DNS question-name encoder. Words enter through a queue-style port (push/full)
// and encoded name bytes leave through another (empty/pop). A payload word
// (is_host low) becomes two upper-case hex characters; the hex text is cut into
// labels of label_limit-1 characters while more than label_limit characters
// remain, then one label for the rest. Host characters are split at dots, and
// host labels longer than LABEL_DEPTH-1 characters are truncated and flagged
// through overflow. Each label leaves as a length byte followed by its
// characters; a host word with name_end closes the name with a zero byte
// marked by is_last. label_limit is written through cfg_valid/cfg_ready/cfg_data
// (reset 63, values 0 and 1 act as 2); the user must write it only while the
// block is idle, as the block itself does not enforce this. The front end
// issues one step at a time (two per payload word, one to three per host word).
// The back end owns the label memory and sets the sustained rate: it stores
// each character, then streams a label out while the result queue has room.
// The label memory needs no clearing pass after reset.
module dns_qname_hex_label_encoder #(
    parameter int LABEL_DEPTH = 63
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire dqhe_pkg::item_t     item,
    output logic                     full,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [5:0]          cfg_data,
    output dqhe_pkg::result_t        result,
    output logic                     empty,
    input  wire logic                pop
);

    import dqhe_pkg::*;

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            cmd_in, cmd_out;
    logic            cmd_wr, cmd_full, cmd_rd, cmd_empty;
    logic [QCW-1:0]  cmd_count;

    // Front end: classifies words and issues store, flush and close commands.
    dqhe_front #(
        .LABEL_DEPTH (LABEL_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_wr    (cmd_wr),
        .cmd       (cmd_in),
        .cmd_full  (cmd_full)
    );

    // Command queue between the two halves.
    dqhe_fifo #(
        .T     (cmd_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cmd_wr),
        .wdata (cmd_in),
        .full  (cmd_full),
        .rd    (cmd_rd),
        .rdata (cmd_out),
        .empty (cmd_empty),
        .count (cmd_count)
    );

    // Back end: label memory and output sequencing.
    dqhe_back #(
        .LABEL_DEPTH (LABEL_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_rd    (cmd_rd),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

    // The queue level is not needed on this side.
    logic unused_count;
    assign unused_count = ^cmd_count;

endmodule

`default_nettype wire

@@ src/dqhe_fifo.sv @@
`default_nettype none

module dqhe_fifo #(
    parameter type T     = logic [7:0],
    parameter int  DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr,
    input  wire T                           wdata,
    output logic                            full,
    input  wire logic                       rd,
    output T                                rdata,
    output logic                            empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                slots [DEPTH];
    logic [PW-1:0]   wptr_reg, wptr_next;
    logic [PW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_wr, do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign count = count_reg;
    assign rdata = slots[rptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Storage slots need no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ src/dqhe_front.sv @@
`default_nettype none

module dqhe_front #(
    parameter int LABEL_DEPTH = 63
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire dqhe_pkg::item_t item,
    output logic               full,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [5:0]    cfg_data,
    output logic               cmd_wr,
    output dqhe_pkg::cmd_t     cmd,
    input  wire logic          cmd_full
);

    import dqhe_pkg::*;

    localparam logic [5:0] DEPTH6 = 6'(LABEL_DEPTH);
    localparam logic [5:0] TRUNC6 = 6'(LABEL_DEPTH - 1);

    item_t            item_reg;
    logic             busy_reg, busy_next;
    fr_step_t         step_reg, step_next;
    logic             first_reg, first_next;
    logic [5:0]       fill_reg, fill_next;
    logic [6:0]       pdone_reg, pdone_next;
    logic             ovf_reg, ovf_next;
    logic [5:0]       limit_reg;

    logic [5:0]        lim, lim_m1, fill_inc;
    logic signed [9:0] chars_after, start_pos, rem;
    logic              hex_flush, adv, last, accept;
    logic [3:0]        nib;

    assign cfg_ready = 1'b1;

    // Effective chunk limit, raised to LIMIT_MIN and clamped to the label store.
    always_comb
    begin
        lim = limit_reg;
        if (limit_reg < LIMIT_MIN)
        begin
            lim = LIMIT_MIN;
        end
        else if (limit_reg > DEPTH6)
        begin
            lim = DEPTH6;
        end
        lim_m1 = lim - 6'd1;
    end

    // Hex label sizing: position of the open label within the hex text.
    always_comb
    begin
        fill_inc    = fill_reg + 6'd1;
        chars_after = signed'({2'b00, pdone_reg, 1'b0}) + 10'sd1
                      + signed'({9'd0, (step_reg == FS_SECOND)});
        start_pos   = chars_after - signed'({4'd0, fill_inc});
        rem         = signed'({2'b00, item_reg.payload_total, 1'b0}) - start_pos;
        if (rem >= 10'sd2 && rem <= signed'({4'd0, lim}))
        begin
            hex_flush = signed'({4'd0, fill_inc}) >= rem;
        end
        else
        begin
            hex_flush = fill_inc >= lim_m1;
        end
        nib = (step_reg == FS_SECOND) ? item_reg.data_byte[3:0] : item_reg.data_byte[7:4];
    end

    // Command generation, one step per cycle while the command queue is not full.
    always_comb
    begin
        adv        = busy_reg && !cmd_full;
        cmd        = '{op: OP_STORE, chr: item_reg.data_byte, addr: fill_reg,
                       len: fill_reg, ovf: ovf_reg, first: first_reg};
        cmd_wr     = 1'b0;
        last       = 1'b0;
        fill_next  = fill_reg;
        pdone_next = pdone_reg;
        ovf_next   = ovf_reg;

        if (!item_reg.is_host)
        begin
            // Payload byte: high nibble, then low nibble.
            cmd.chr = hex_char(nib);
            cmd.op  = hex_flush ? OP_STORE_FLUSH : OP_STORE;
            cmd.len = fill_inc;
            cmd_wr  = adv;
            last    = (step_reg == FS_SECOND);
            if (adv)
            begin
                fill_next = hex_flush ? 6'd0 : fill_inc;
                if (last)
                begin
                    pdone_next = pdone_reg + 7'd1;
                end
            end
        end
        else
        begin
            case (step_reg)
                FS_FIRST:
                begin
                    // Host character: split at dots, truncate long labels.
                    last = !item_reg.name_end;
                    if (item_reg.data_byte == DOT_CHAR)
                    begin
                        cmd.op = OP_FLUSH;
                        cmd_wr = adv && (fill_reg != 6'd0);
                        if (adv)
                        begin
                            fill_next = 6'd0;
                        end
                    end
                    else if (fill_reg < TRUNC6)
                    begin
                        cmd_wr = adv;
                        if (adv)
                        begin
                            fill_next = fill_inc;
                        end
                    end
                    else if (adv)
                    begin
                        ovf_next = 1'b1;
                    end
                end
                FS_SECOND:
                begin
                    // Closing: send the open label, if any.
                    cmd.op = OP_FLUSH;
                    cmd_wr = adv && (fill_reg != 6'd0);
                    if (adv)
                    begin
                        fill_next = 6'd0;
                    end
                end
                FS_CLOSE:
                begin
                    cmd.op = OP_CLOSE;
                    cmd_wr = adv;
                    last   = 1'b1;
                    if (adv)
                    begin
                        fill_next  = 6'd0;
                        pdone_next = 7'd0;
                        ovf_next   = 1'b0;
                    end
                end
                default:
                begin
                    last = 1'b1;
                end
            endcase
        end
    end

    // Input handshake: a new word may enter as the last step issues.
    always_comb
    begin
        full       = busy_reg && !(adv && last);
        accept     = push && !full;
        busy_next  = busy_reg;
        step_next  = step_reg;
        first_next = cmd_wr ? 1'b0 : first_reg;
        if (adv && !last)
        begin
            step_next = (step_reg == FS_FIRST) ? FS_SECOND : FS_CLOSE;
        end
        if (adv && last)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            busy_next  = 1'b1;
            first_next = 1'b1;
            step_next  = FS_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= FS_FIRST;
            first_reg <= 1'b0;
            fill_reg  <= 6'd0;
            pdone_reg <= 7'd0;
            ovf_reg   <= 1'b0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            first_reg <= first_next;
            fill_reg  <= fill_next;
            pdone_reg <= pdone_next;
            ovf_reg   <= ovf_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Held input word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

endmodule

`default_nettype wire

@@ src/dqhe_back.sv @@
`default_nettype none

module dqhe_back #(
    parameter int LABEL_DEPTH = 63
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dqhe_pkg::cmd_t  cmd,
    input  wire logic            cmd_empty,
    output logic                 cmd_rd,
    output dqhe_pkg::result_t    result,
    output logic                 empty,
    input  wire logic            pop
);

    import dqhe_pkg::*;

    localparam int AW  = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;
    localparam int OCW = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]      label_mem [LABEL_DEPTH];
    logic [7:0]      rdata_reg;

    bk_state_t       state_reg, state_next;
    logic [5:0]      len_reg, len_next;
    logic [5:0]      idx_reg, idx_next;
    logic            bovf_reg, bovf_next;
    logic [6:0]      cnt_reg, cnt_next;
    logic            pend_reg, pend_next;
    logic            pkeep_reg, pkeep_next;
    logic            povf_reg, povf_next;

    logic            mem_we, mem_re, room, keep;
    logic            opush, ofull;
    result_t         oword;
    logic [OCW-1:0]  ocount;

    // A slot must be free for each word already in flight from the memory.
    assign room = ((OCW+1)'(ocount) + (OCW+1)'(pend_reg)) < (OCW+1)'(QUEUE_DEPTH);
    assign keep = cnt_reg < MAX_OUT;

    // Sequencer: store characters, stream a label out of the memory, or close the name.
    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        bovf_next  = bovf_reg;
        cnt_next   = cnt_reg;
        pend_next  = 1'b0;
        pkeep_next = pkeep_reg;
        povf_next  = povf_reg;
        cmd_rd     = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        opush      = pend_reg && pkeep_reg;
        oword      = '{out_byte: rdata_reg, is_last: 1'b0, overflow: povf_reg};

        case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_rd    = 1'b1;
                    len_next  = cmd.len;
                    bovf_next = cmd.ovf;
                    if (cmd.first)
                    begin
                        cnt_next = 7'd0;
                    end
                    case (cmd.op)
                        OP_STORE:
                        begin
                            mem_we = 1'b1;
                        end
                        OP_STORE_FLUSH:
                        begin
                            mem_we     = 1'b1;
                            state_next = BK_LEN;
                        end
                        OP_FLUSH:
                        begin
                            state_next = BK_LEN;
                        end
                        OP_CLOSE:
                        begin
                            state_next = BK_CLOSE;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_LEN:
            begin
                if (room)
                begin
                    opush      = keep;
                    oword      = '{out_byte: {2'b00, len_reg}, is_last: 1'b0,
                                   overflow: bovf_reg};
                    cnt_next   = keep ? cnt_reg + 7'd1 : cnt_reg;
                    idx_next   = 6'd0;
                    state_next = BK_CHAR;
                end
            end
            BK_CHAR:
            begin
                if (room)
                begin
                    mem_re     = 1'b1;
                    pend_next  = 1'b1;
                    pkeep_next = keep;
                    povf_next  = bovf_reg;
                    cnt_next   = keep ? cnt_reg + 7'd1 : cnt_reg;
                    idx_next   = idx_reg + 6'd1;
                    if (idx_reg == len_reg - 6'd1)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_CLOSE:
            begin
                if (room)
                begin
                    opush      = keep;
                    oword      = '{out_byte: END_BYTE, is_last: 1'b1, overflow: bovf_reg};
                    cnt_next   = keep ? cnt_reg + 7'd1 : cnt_reg;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            len_reg   <= 6'd0;
            idx_reg   <= 6'd0;
            bovf_reg  <= 1'b0;
            cnt_reg   <= 7'd0;
            pend_reg  <= 1'b0;
            pkeep_reg <= 1'b0;
            povf_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            bovf_reg  <= bovf_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            pkeep_reg <= pkeep_next;
            povf_reg  <= povf_next;
        end
    end

    // Label memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            label_mem[cmd.addr[AW-1:0]] <= cmd.chr;
        end
        if (mem_re)
        begin
            rdata_reg <= label_mem[idx_reg[AW-1:0]];
        end
    end

    // Result queue toward the consumer.
    dqhe_fifo #(
        .T     (result_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (opush),
        .wdata (oword),
        .full  (ofull),
        .rd    (pop),
        .rdata (result),
        .empty (empty),
        .count (ocount)
    );

    // The room check keeps the queue from ever filling past its last slot.
    logic unused_full;
    assign unused_full = ofull;

endmodule

`default_nettype wire
